/* rtl/v3alu_pkg.sv */
// ----------------------------------------------------------------------------
// v3alu_pkg
// opcodes, status codes and saturation helpers shared by the vector alu
// ----------------------------------------------------------------------------
package v3alu_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_CROSS = 4'd2,
        OP_DOT   = 4'd3,
        OP_ADD_S = 4'd4,
        OP_SUB_S = 4'd5,
        OP_MUL_S = 4'd6,
        OP_DIV_S = 4'd7,
        OP_MAG   = 4'd8,
        OP_NORM  = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // one stage per root bit of a 64-bit radicand
    localparam int SQ_STAGES = 32;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] W_MAX   = 66'sh0_7fff_ffff;
    localparam logic signed [65:0] W_MIN   = -66'sh0_8000_0000;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_t sat66(input logic signed [65:0] v);
        sat_t r;
        if (v > W_MAX) begin
            r.sat = 1'b1;
            r.val = S32_MAX;
        end else if (v < W_MIN) begin
            r.sat = 1'b1;
            r.val = S32_MIN;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // apply sign to an unsigned quotient and clamp
    function automatic sat_t quot_fix(input logic [32:0] q, input logic ovf,
                                      input logic neg);
        sat_t r;
        r.sat = 1'b0;
        r.val = '0;
        if (neg) begin
            if (ovf || q > 33'h0_8000_0000) begin
                r.sat = 1'b1;
                r.val = S32_MIN;
            end else begin
                r.val = ~q[31:0] + 32'd1;
            end
        end else begin
            if (ovf || q[32] || q[31]) begin
                r.sat = 1'b1;
                r.val = S32_MAX;
            end else begin
                r.val = q[31:0];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/v3alu_lane.sv */
// ----------------------------------------------------------------------------
// v3alu_lane
// one component lane: two multipliers, then add/sub/shift and clamp
// ----------------------------------------------------------------------------
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  v3alu_pkg::op_t         op,
    input  logic signed [31:0]     a_i,
    input  logic signed [31:0]     b_i,
    input  logic signed [31:0]     a_j,
    input  logic signed [31:0]     b_k,
    input  logic signed [31:0]     a_k,
    input  logic signed [31:0]     b_j,
    input  logic signed [31:0]     s,
    output logic signed [63:0]     p1,
    output v3alu_pkg::sat_t        res,
    output logic signed [31:0]     a_out
);
    import v3alu_pkg::*;

    logic signed [31:0] m1_x, m1_y;
    logic signed [63:0] p1_next, p2_next;
    logic signed [63:0] p1_reg, p2_reg;
    op_t                op_a_reg;
    logic signed [31:0] a_a_reg, b_a_reg, s_a_reg;
    logic signed [65:0] wide;
    sat_t               res_next, res_reg;
    logic signed [31:0] a_b_reg;

    // operand select for the shared multiplier
    always_comb begin
        m1_x = a_i;
        m1_y = b_i;
        case (op)
            OP_CROSS: begin
                m1_x = a_j;
                m1_y = b_k;
            end
            OP_MAG, OP_NORM: m1_y = a_i;
            OP_MUL_S:        m1_y = s;
            default: ;
        endcase
    end

    assign p1_next = m1_x * m1_y;
    assign p2_next = a_k * b_j;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            op_a_reg <= op;
            a_a_reg  <= a_i;
            b_a_reg  <= b_i;
            s_a_reg  <= s;
        end
    end

    always_comb begin
        wide = '0;
        case (op_a_reg)
            OP_ADD:   wide = 66'(a_a_reg) + 66'(b_a_reg);
            OP_SUB:   wide = 66'(a_a_reg) - 66'(b_a_reg);
            OP_ADD_S: wide = 66'(a_a_reg) + 66'(s_a_reg);
            OP_SUB_S: wide = 66'(a_a_reg) - 66'(s_a_reg);
            OP_MUL_S: wide = 66'(p1_reg) >>> FRAC_BITS;
            OP_CROSS: wide = (66'(p1_reg) - 66'(p2_reg)) >>> FRAC_BITS;
            default:  wide = '0;
        endcase
        res_next = sat66(wide);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            a_b_reg <= a_a_reg;
        end
    end

    assign p1    = p1_reg;
    assign res   = res_reg;
    assign a_out = a_b_reg;

endmodule

/* rtl/v3alu_isqrt.sv */
// ----------------------------------------------------------------------------
// v3alu_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module v3alu_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] n_in,
    output logic [31:0] root
);
    import v3alu_pkg::*;

    logic [63:0] n_reg [SQ_STAGES];
    logic [63:0] r_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam int SH = 2 * (SQ_STAGES - 1 - k);
        logic [63:0] n_cur, r_cur, trial, n_next, r_next;

        if (k == 0) begin : g_first
            assign n_cur = n_in;
            assign r_cur = '0;
        end else begin : g_rest
            assign n_cur = n_reg[k-1];
            assign r_cur = r_reg[k-1];
        end

        assign trial = r_cur + (64'd1 << SH);

        always_comb begin
            if (n_cur >= trial) begin
                n_next = n_cur - trial;
                r_next = (r_cur >> 1) + (64'd1 << SH);
            end else begin
                n_next = n_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQ_STAGES-1][31:0];

endmodule

/* rtl/v3alu_div.sv */
// ----------------------------------------------------------------------------
// v3alu_div
// pipelined unsigned restoring divider of (dvd << FRAC_BITS) by dsr
// ----------------------------------------------------------------------------
module v3alu_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] dvd,
    input  logic [31:0] dsr,
    output logic [32:0] q,
    output logic        ovf
);
    localparam int DW = 32 + FRAC_BITS;

    logic [DW-1:0] d_reg   [DW];
    logic [31:0]   rem_reg [DW];
    logic [31:0]   dsr_reg [DW];
    logic [32:0]   q_reg   [DW];
    logic          ovf_reg [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0] d_cur, d_next;
        logic [31:0]   rem_cur, dsr_cur, rem_next;
        logic [32:0]   q_cur, q_next, trial, diff;
        logic          ovf_cur, ovf_next, ge;

        if (k == 0) begin : g_first
            assign d_cur   = {dvd, {FRAC_BITS{1'b0}}};
            assign rem_cur = '0;
            assign dsr_cur = dsr;
            assign q_cur   = '0;
            assign ovf_cur = 1'b0;
        end else begin : g_rest
            assign d_cur   = d_reg[k-1];
            assign rem_cur = rem_reg[k-1];
            assign dsr_cur = dsr_reg[k-1];
            assign q_cur   = q_reg[k-1];
            assign ovf_cur = ovf_reg[k-1];
        end

        assign trial    = {rem_cur, d_cur[DW-1]};
        assign diff     = trial - {1'b0, dsr_cur};
        assign ge       = trial >= {1'b0, dsr_cur};
        assign rem_next = ge ? diff[31:0] : trial[31:0];
        assign d_next   = d_cur << 1;
        assign q_next   = {q_cur[31:0], ge};
        // any quotient bit pushed past bit 32 means a clamped result
        assign ovf_next = ovf_cur | q_cur[32];

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_next;
                rem_reg[k] <= rem_next;
                dsr_reg[k] <= dsr_cur;
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_next;
            end
        end
    end

    assign q   = q_reg[DW-1];
    assign ovf = ovf_reg[DW-1];

endmodule

/* rtl/vector3_alu.sv */
// ----------------------------------------------------------------------------
// vector3_alu
// three-component vector alu in signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   input words arrive on s_valid/s_ready with an opcode, vectors a and b and
//   a scalar; one result word leaves on m_valid/m_ready per input word
//   (vector result, scalar result and a status code)
// pipeline: every opcode takes the same path from acceptance to m_valid;
//   the 32-stage square root is followed by the 32 + FRAC_BITS stage divider
//   that normalise and scalar divide share (default FRAC_BITS 16 gives Q16.16)
// throughput: one word per cycle unless the output stalls; three lanes, each
//   with two multipliers and its own divider, work on x, y and z side by side
// stall: while m_valid is high and m_ready low the whole pipeline freezes
//   and s_ready drops; nothing is lost or duplicated, and s_ready returns in
//   the cycle the output word is taken
// reset: aresetn (synchronous, active low) empties the pipeline; no word is
//   in flight afterwards and m_valid is low; s_ready is low during reset
// ----------------------------------------------------------------------------
module vector3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_op,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by,
    input  logic signed [31:0] s_bz,
    input  logic signed [31:0] s_scalar_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_x,
    output logic signed [31:0] m_res_y,
    output logic signed [31:0] m_res_z,
    output logic signed [31:0] m_res_scalar,
    output logic [1:0]         m_status
);
    import v3alu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int NB = SQ_STAGES + DW;

    // per-word record that rides alongside the root and divider pipelines
    typedef struct packed {
        op_t             op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] v;
        logic            sat;
        logic [31:0]     sc;
        logic            s_neg;
        logic            s_zero;
        logic [31:0]     s_mag;
        logic [31:0]     root;
        logic            len_zero;
    } band_t;

    logic m_valid_reg;

    // global advance: the pipeline moves unless the output word is stuck
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && aresetn;

    // input register
    logic               v0_reg;
    op_t                op0_reg;
    logic signed [31:0] a0_reg [3];
    logic signed [31:0] b0_reg [3];
    logic signed [31:0] s0_reg;

    // side carries for lane stages
    logic               va_reg, vb_reg;
    op_t                opa_reg, opb_reg;
    logic signed [31:0] sa_reg, sb_reg;

    logic signed [63:0] p1 [3];
    sat_t               lane_res [3];
    logic signed [31:0] lane_a [3];

    logic signed [65:0] sum_next, sum_reg;
    sat_t               dot;

    band_t              band_in, band_fix;
    band_t              band_reg [NB];
    logic [NB-1:0]      vband_reg;
    logic [31:0]        root;

    logic [32:0]        q [3];
    logic               ovf [3];
    sat_t               qfix [3];

    logic [2:0][31:0]   vec_next, vec_reg;
    logic [31:0]        sc_next, sc_reg;
    status_t            st_next, st_reg;
    logic               any_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vband_reg <= '0;
        end else if (adv) begin
            v0_reg    <= s_valid;
            va_reg    <= v0_reg;
            vb_reg    <= va_reg;
            vband_reg <= {vband_reg[NB-2:0], vb_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op0_reg   <= op_t'(s_op);
            a0_reg[0] <= s_ax;
            a0_reg[1] <= s_ay;
            a0_reg[2] <= s_az;
            b0_reg[0] <= s_bx;
            b0_reg[1] <= s_by;
            b0_reg[2] <= s_bz;
            s0_reg    <= s_scalar_in;
            opa_reg   <= op0_reg;
            opb_reg   <= opa_reg;
            sa_reg    <= s0_reg;
            sb_reg    <= sa_reg;
            sum_reg   <= sum_next;
        end
    end

    // component lanes; lane i forms a[j]*b[k] - a[k]*b[j] for the cross
    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk  (aclk),
            .en    (adv),
            .op    (op0_reg),
            .a_i   (a0_reg[i]),
            .b_i   (b0_reg[i]),
            .a_j   (a0_reg[J]),
            .b_k   (b0_reg[K]),
            .a_k   (a0_reg[K]),
            .b_j   (b0_reg[J]),
            .s     (s0_reg),
            .p1    (p1[i]),
            .res   (lane_res[i]),
            .a_out (lane_a[i])
        );
    end

    // merge: exact sum of products, shifted down by FRAC_BITS once for the dot product
    assign sum_next = 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);
    assign dot      = sat66(sum_reg >>> FRAC_BITS);

    always_comb begin
        band_in          = '0;
        band_in.op       = opb_reg;
        band_in.s_neg    = sb_reg[31];
        band_in.s_zero   = (sb_reg == '0);
        band_in.s_mag    = sb_reg[31] ? (~sb_reg + 32'd1) : sb_reg;
        for (int i = 0; i < 3; i++) begin
            band_in.a[i] = lane_a[i];
            band_in.v[i] = lane_res[i].val;
        end
        band_in.sat = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat |
                      ((opb_reg == OP_DOT) & dot.sat);
        band_in.sc  = (opb_reg == OP_DOT) ? dot.val : '0;
    end

    // sum of squares is non-negative and fits 64 bits unsigned
    v3alu_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .n_in (sum_reg[63:0]),
        .root (root)
    );

    // root arrives together with band stage SQ_STAGES-1
    always_comb begin
        band_fix          = band_reg[SQ_STAGES-1];
        band_fix.root     = root;
        band_fix.len_zero = (root == '0);
    end

    for (genvar k = 0; k < NB; k++) begin : g_band
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (adv) band_reg[k] <= band_in;
            end
        end else if (k == SQ_STAGES) begin : g_root
            always_ff @(posedge aclk) begin
                if (adv) band_reg[k] <= band_fix;
            end
        end else begin : g_shift
            always_ff @(posedge aclk) begin
                if (adv) band_reg[k] <= band_reg[k-1];
            end
        end
    end

    // per-lane dividers: |a| / |s| for scalar divide, |a| / length for normalise
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [31:0] a_cur, a_mag, dsr;
        logic        neg;
        assign a_cur = band_reg[SQ_STAGES-1].a[i];
        assign a_mag = a_cur[31] ? (~a_cur + 32'd1) : a_cur;
        assign dsr   = (band_reg[SQ_STAGES-1].op == OP_NORM) ? root
                                                             : band_reg[SQ_STAGES-1].s_mag;

        v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk (aclk),
            .en   (adv),
            .dvd  (a_mag),
            .dsr  (dsr),
            .q    (q[i]),
            .ovf  (ovf[i])
        );

        assign neg = band_reg[NB-1].a[i][31] ^
                     ((band_reg[NB-1].op == OP_DIV_S) & band_reg[NB-1].s_neg);
        assign qfix[i] = quot_fix(q[i], ovf[i], neg);
    end

    // final merge of lane results and status
    always_comb begin
        vec_next = band_reg[NB-1].v;
        sc_next  = band_reg[NB-1].sc;
        any_sat  = band_reg[NB-1].sat;
        st_next  = ST_OK;
        case (band_reg[NB-1].op)
            OP_DIV_S: begin
                if (band_reg[NB-1].s_zero) begin
                    // divide by zero: push each non-zero component to its rail
                    st_next = ST_DIV0;
                    for (int i = 0; i < 3; i++) begin
                        if (band_reg[NB-1].a[i][31])
                            vec_next[i] = S32_MIN;
                        else if (band_reg[NB-1].a[i] != '0)
                            vec_next[i] = S32_MAX;
                        else
                            vec_next[i] = '0;
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        vec_next[i] = qfix[i].val;
                        any_sat     = any_sat | qfix[i].sat;
                    end
                end
            end
            OP_NORM: begin
                if (band_reg[NB-1].len_zero) begin
                    vec_next = band_reg[NB-1].a;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        vec_next[i] = qfix[i].val;
                        any_sat     = any_sat | qfix[i].sat;
                    end
                end
            end
            OP_MAG: begin
                sc_next = band_reg[NB-1].root[31] ? S32_MAX : band_reg[NB-1].root;
                any_sat = band_reg[NB-1].root[31];
            end
            default: ;
        endcase
        if (st_next != ST_DIV0 && any_sat) st_next = ST_SAT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vband_reg[NB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg <= vec_next;
            sc_reg  <= sc_next;
            st_reg  <= st_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_res_x      = vec_reg[0];
    assign m_res_y      = vec_reg[1];
    assign m_res_z      = vec_reg[2];
    assign m_res_scalar = sc_reg;
    assign m_status     = st_reg;

    // a scalar result always comes with a zero vector
    a_scalar_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res_scalar != '0 |-> m_res_x == '0 && m_res_y == '0 && m_res_z == '0)
        else $error("scalar and vector result both non-zero");

    // divide by zero only ever carries a vector result
    a_div0_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_res_scalar == '0)
        else $error("divide by zero word with scalar result");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_SAT || m_status == ST_DIV0)
        else $error("undefined status code");

    // a frozen pipeline keeps its occupancy
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vband_reg) && $stable(vb_reg))
        else $error("pipeline moved while output stalled");

endmodule
